>>> sv/gbc_pkg.sv
// Shared types, constants and elaboration-time helpers for the gamma,
// brightness and contrast ramp. No dependencies; every RTL file uses it.
package gbc_pkg;

    localparam int LOG_STEPS = 16;
    localparam logic [16:0] ONE_Q16 = 17'h10000;
    localparam logic [15:0] GAMMA_UNITY = 16'd4096;

    // Reciprocal division for the channel gains.
    localparam int RECIP_SHIFT = 37;
    localparam logic [12:0] DEN_RB = 13'd1000;
    localparam logic [12:0] DEN_G = 13'd5000;
    localparam logic [27:0] RECIP_RB = 28'((64'd1 << RECIP_SHIFT) / DEN_RB);
    localparam logic [27:0] RECIP_G = 28'((64'd1 << RECIP_SHIFT) / DEN_G);
    localparam logic [12:0] CH_DEN [3] = '{DEN_RB, DEN_G, DEN_RB};
    localparam logic [27:0] CH_RECIP [3] = '{RECIP_RB, RECIP_G, RECIP_RB};

    typedef struct packed {
        logic [15:0]        brightness;
        logic [15:0]        contrast;
        logic [15:0]        gamma_recip;
        logic signed [7:0]  temperature;
    } cfg_t;

    // Floor square root, evaluated at elaboration only.
    function automatic logic [63:0] isqrt64(input logic [63:0] n);
        logic [63:0] rem;
        logic [63:0] res;
        logic [63:0] probe;
        rem = n;
        res = '0;
        probe = 64'd1 << 62;
        for (int i = 0; i < 32; i++)
        begin
            if (probe > rem)
                probe = probe >> 2;
        end
        for (int i = 0; i < 32; i++)
        begin
            if (probe != 64'd0)
            begin
                if (rem >= res + probe)
                begin
                    rem = rem - (res + probe);
                    res = (res >> 1) + probe;
                end
                else
                begin
                    res = res >> 1;
                end
                probe = probe >> 2;
            end
        end
        return res;
    endfunction

    // 2^(-2^-j) in Q0.32, found by repeated square roots of one half.
    function automatic logic [31:0] exp_root(input int j);
        logic [63:0] r;
        r = isqrt64(64'd1 << 63);
        for (int i = 2; i <= LOG_STEPS; i++)
        begin
            if (i <= j)
                r = isqrt64(r << 32);
        end
        return r[31:0];
    endfunction

endpackage

>>> sv/gbc_log2.sv
// Pipelined negated log2 of the normalized level, scaled by the exponent.
// Uses gbc_pkg; one squaring multiplier per fraction bit.
module gbc_log2 (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        en,
    input  logic        in_valid,
    input  logic [16:0] in_x,
    input  logic [15:0] gamma_recip,
    output logic        out_valid,
    output logic [16:0] out_x,
    output logic [23:0] out_y
);

    localparam int NSTG = gbc_pkg::LOG_STEPS + 3;

    logic        v_reg [0:NSTG-1];
    logic [16:0] x_reg [0:NSTG-1];
    logic [30:0] m_reg [0:gbc_pkg::LOG_STEPS];
    logic [15:0] frac_reg [0:gbc_pkg::LOG_STEPS];
    logic [3:0]  k_reg [0:gbc_pkg::LOG_STEPS];
    logic [20:0] neg_reg;
    logic [23:0] y_reg;

    logic [3:0]  msb;
    logic [30:0] m0;
    logic [30:0] m_next [1:gbc_pkg::LOG_STEPS];
    logic        sq_bit [1:gbc_pkg::LOG_STEPS];
    logic [20:0] neg_next;
    logic [36:0] ny;
    logic [23:0] y_next;

    always_comb
    begin
        msb = '0;
        for (int i = 1; i < 16; i++)
        begin
            if (in_x[i])
                msb = 4'(i);
        end
    end

    // Mantissa in Q1.30.
    assign m0 = {15'd0, in_x[15:0]} << (5'd30 - {1'b0, msb});

    for (genvar s = 1; s <= gbc_pkg::LOG_STEPS; s++)
    begin : g_sq
        logic [61:0] prod;
        logic [31:0] sq;
        assign prod = m_reg[s-1] * m_reg[s-1];
        assign sq = prod[61:30];
        assign sq_bit[s] = sq[31];
        assign m_next[s] = sq[31] ? sq[31:1] : sq[30:0];
    end

    assign neg_next = {(5'd16 - {1'b0, k_reg[gbc_pkg::LOG_STEPS]}), 16'd0}
                    - {5'd0, frac_reg[gbc_pkg::LOG_STEPS]};
    assign ny = neg_reg * gamma_recip;
    assign y_next = 24'((ny + 37'd2048) >> 12);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < NSTG; s++)
                v_reg[s] <= 1'b0;
        end
        else if (en)
        begin
            v_reg[0] <= in_valid;
            for (int s = 1; s < NSTG; s++)
                v_reg[s] <= v_reg[s-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0] <= in_x;
            m_reg[0] <= m0;
            k_reg[0] <= msb;
            frac_reg[0] <= '0;
            for (int s = 1; s < NSTG; s++)
                x_reg[s] <= x_reg[s-1];
            for (int s = 1; s <= gbc_pkg::LOG_STEPS; s++)
            begin
                m_reg[s] <= m_next[s];
                k_reg[s] <= k_reg[s-1];
                frac_reg[s] <= {frac_reg[s-1][14:0], sq_bit[s]};
            end
            neg_reg <= neg_next;
            y_reg <= y_next;
        end
    end

    assign out_valid = v_reg[NSTG-1];
    assign out_x = x_reg[NSTG-1];
    assign out_y = y_reg;

endmodule

>>> sv/gbc_exp2.sv
// Pipelined exp2 of the negated scaled log, plus the special cases of the power.
// Uses gbc_pkg; one multiplier by a constant root per fraction bit.
module gbc_exp2 (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        en,
    input  logic        in_valid,
    input  logic [16:0] in_x,
    input  logic [23:0] in_y,
    input  logic [15:0] gamma_recip,
    output logic        out_valid,
    output logic [16:0] out_v
);

    localparam int NSTG = gbc_pkg::LOG_STEPS + 2;
    localparam int LAST = gbc_pkg::LOG_STEPS;

    logic        v_reg [0:NSTG-1];
    logic [16:0] x_reg [0:LAST];
    logic [31:0] r_reg [0:LAST];
    logic        one_reg [0:LAST];
    logic [15:0] fp_reg [0:LAST];
    logic [4:0]  ip_reg [0:LAST];
    logic        deep_reg [0:LAST];
    logic [16:0] v_out_reg;

    logic        deep0;
    logic [31:0] r_next [1:LAST];
    logic        one_next [1:LAST];
    logic [33:0] sum;
    logic [33:0] pow;
    logic [16:0] pow_cl;
    logic [16:0] v_next;

    assign deep0 = in_y[23:16] > 8'd16;

    for (genvar j = 1; j <= LAST; j++)
    begin : g_mul
        localparam logic [31:0] ROOT = gbc_pkg::exp_root(j);
        logic [63:0] prod;
        logic [63:0] rnd;
        logic        take;
        assign prod = r_reg[j-1] * ROOT;
        assign rnd = prod + 64'h8000_0000;
        assign take = fp_reg[j-1][LAST-j];
        assign r_next[j] = !take ? r_reg[j-1] : (one_reg[j-1] ? ROOT : rnd[63:32]);
        assign one_next[j] = one_reg[j-1] & !take;
    end

    // While one_reg is set, the running product is exactly 1.0.
    assign sum = {1'b0, one_reg[LAST], r_reg[LAST]}
               + (34'd1 << (6'd15 + {1'b0, ip_reg[LAST]}));
    assign pow = sum >> (6'd16 + {1'b0, ip_reg[LAST]});
    assign pow_cl = (pow > 34'(gbc_pkg::ONE_Q16)) ? gbc_pkg::ONE_Q16 : pow[16:0];

    always_comb
    begin
        priority if (gamma_recip == gbc_pkg::GAMMA_UNITY
                     || x_reg[LAST] == gbc_pkg::ONE_Q16)
            v_next = x_reg[LAST];
        else if (gamma_recip == 16'd0)
            v_next = gbc_pkg::ONE_Q16;
        else if (x_reg[LAST] == 17'd0 || deep_reg[LAST])
            v_next = 17'd0;
        else
            v_next = pow_cl;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < NSTG; s++)
                v_reg[s] <= 1'b0;
        end
        else if (en)
        begin
            v_reg[0] <= in_valid;
            for (int s = 1; s < NSTG; s++)
                v_reg[s] <= v_reg[s-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0] <= in_x;
            r_reg[0] <= '0;
            one_reg[0] <= 1'b1;
            fp_reg[0] <= in_y[15:0];
            ip_reg[0] <= deep0 ? 5'd0 : in_y[20:16];
            deep_reg[0] <= deep0;
            for (int s = 1; s <= LAST; s++)
            begin
                x_reg[s] <= x_reg[s-1];
                r_reg[s] <= r_next[s];
                one_reg[s] <= one_next[s];
                fp_reg[s] <= fp_reg[s-1];
                ip_reg[s] <= ip_reg[s-1];
                deep_reg[s] <= deep_reg[s-1];
            end
            v_out_reg <= v_next;
        end
    end

    assign out_valid = v_reg[NSTG-1];
    assign out_v = v_out_reg;

endmodule

>>> sv/gbc_tone.sv
// Contrast, brightness, clamp and per-channel color temperature gain.
// Uses gbc_pkg; divides by the gain denominators through reciprocal multiplies.
module gbc_tone (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          in_valid,
    input  logic [16:0]   in_v,
    input  gbc_pkg::cfg_t cfg,
    output logic          out_valid,
    output logic [47:0]   out_rgb
);

    localparam int NSTG = 6;

    logic               v_reg [0:NSTG-1];
    logic signed [34:0] t_reg;
    logic [16:0]        base_reg;
    logic [29:0]        p_reg [3];
    logic [29:0]        w_reg [3];
    logic [29:0]        w2_reg [3];
    logic [16:0]        q0_reg [3];
    logic [15:0]        o_reg [3];

    logic signed [7:0]  tc;
    logic signed [13:0] num_s [3];
    logic signed [17:0] dv;
    logic signed [34:0] t_next;
    logic signed [34:0] sh;
    logic signed [21:0] bsum;
    logic [16:0]        base_next;

    always_comb
    begin
        priority if (cfg.temperature > 8'sd100)
            tc = 8'sd100;
        else if (cfg.temperature < -8'sd100)
            tc = -8'sd100;
        else
            tc = cfg.temperature;
    end

    assign num_s[0] = 14'sd1000 + 14'(tc);
    assign num_s[1] = 14'sd5000 + 14'(tc);
    assign num_s[2] = 14'sd1000 - 14'(tc);

    assign dv = $signed({1'b0, in_v}) - 18'sd32768;
    assign t_next = dv * $signed({1'b0, cfg.contrast});

    assign sh = (t_reg + 35'sd8192) >>> 14;
    assign bsum = 22'(sh) + $signed({5'd0, cfg.brightness, 1'b0});

    always_comb
    begin
        priority if (bsum < 22'sd0)
            base_next = '0;
        else if (bsum > 22'sd65536)
            base_next = gbc_pkg::ONE_Q16;
        else
            base_next = bsum[16:0];
    end

    for (genvar c = 0; c < 3; c++)
    begin : g_ch
        localparam logic [12:0] DEN = gbc_pkg::CH_DEN[c];
        localparam logic [27:0] RECIP = gbc_pkg::CH_RECIP[c];
        logic [29:0] p_next;
        logic [45:0] w_full;
        logic [57:0] wm;
        logic [29:0] qd;
        logic [29:0] rem;
        logic [17:0] q;

        assign p_next = base_reg * num_s[c][12:0];
        // Round-to-nearest of base * 65535 * num / (65536 * den), split into
        // a shift and a division by den.
        assign w_full = ({p_reg[c], 16'd0} - 46'(p_reg[c]) + (46'(DEN) << 15)) >> 16;
        assign wm = w_reg[c] * RECIP;
        assign qd = q0_reg[c] * DEN;
        assign rem = w2_reg[c] - qd;
        assign q = (rem >= 30'(DEN)) ? 18'(q0_reg[c]) + 18'd1 : 18'(q0_reg[c]);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                p_reg[c] <= p_next;
                w_reg[c] <= w_full[29:0];
                w2_reg[c] <= w_reg[c];
                q0_reg[c] <= 17'(wm >> gbc_pkg::RECIP_SHIFT);
                o_reg[c] <= (q > 18'd65535) ? 16'hFFFF : q[15:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < NSTG; s++)
                v_reg[s] <= 1'b0;
        end
        else if (en)
        begin
            v_reg[0] <= in_valid;
            for (int s = 1; s < NSTG; s++)
                v_reg[s] <= v_reg[s-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t_reg <= t_next;
            base_reg <= base_next;
        end
    end

    assign out_valid = v_reg[NSTG-1];
    assign out_rgb = {o_reg[2], o_reg[1], o_reg[0]};

endmodule

>>> sv/gamma_brightness_contrast_ramp.sv
// Throughput: one word per cycle while the skid register is empty.
// Every stage holds at most one multiplier per channel.
// The 44-stage pipeline advances as a whole; a skid register behind the
// output register keeps one more word when the sink stalls.
// Reset clears all valid bits and loads the neutral register values.
module gamma_brightness_contrast_ramp (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] level
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // [15:0] red_value, [31:16] green_value,
                                        // [47:32] blue_value
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    typedef enum logic [7:0] {
        REG_BRIGHTNESS  = 8'd0,
        REG_CONTRAST    = 8'd1,
        REG_GAMMA_RECIP = 8'd2,
        REG_COLOR_TEMP  = 8'd3
    } reg_index_t;

    gbc_pkg::cfg_t cfg_reg;

    logic        en;
    logic        xv_reg;
    logic [16:0] x_reg;
    logic [16:0] x_next;

    logic        lg_valid;
    logic [16:0] lg_x;
    logic [23:0] lg_y;
    logic        ex_valid;
    logic [16:0] ex_v;
    logic        tn_valid;
    logic [47:0] tn_rgb;

    logic        out_valid_reg;
    logic [47:0] out_reg;
    logic        skid_valid_reg;
    logic [47:0] skid_reg;
    logic        out_free;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.brightness <= 16'd16384;
            cfg_reg.contrast <= 16'd16384;
            cfg_reg.gamma_recip <= gbc_pkg::GAMMA_UNITY;
            cfg_reg.temperature <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (reg_index_t'(cfg_index))
                REG_BRIGHTNESS:  cfg_reg.brightness <= cfg_data;
                REG_CONTRAST:    cfg_reg.contrast <= cfg_data;
                REG_GAMMA_RECIP: cfg_reg.gamma_recip <= cfg_data;
                REG_COLOR_TEMP:  cfg_reg.temperature <= cfg_data[7:0];
                default:         cfg_reg <= cfg_reg;
            endcase
        end
    end

    // The pipeline moves only while the skid register is empty.
    assign en = !skid_valid_reg;
    assign s_axis_tready = en;

    // level * 65536 / 255 rounded: level * 257 plus one for the upper half.
    assign x_next = (s_axis_tdata == 8'hFF) ? gbc_pkg::ONE_Q16
                  : 17'({s_axis_tdata, s_axis_tdata}) + 17'(s_axis_tdata[7]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            xv_reg <= 1'b0;
        else if (en)
            xv_reg <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            x_reg <= x_next;
    end

    gbc_log2 u_log2 (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (en),
        .in_valid    (xv_reg),
        .in_x        (x_reg),
        .gamma_recip (cfg_reg.gamma_recip),
        .out_valid   (lg_valid),
        .out_x       (lg_x),
        .out_y       (lg_y)
    );

    gbc_exp2 u_exp2 (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (en),
        .in_valid    (lg_valid),
        .in_x        (lg_x),
        .in_y        (lg_y),
        .gamma_recip (cfg_reg.gamma_recip),
        .out_valid   (ex_valid),
        .out_v       (ex_v)
    );

    gbc_tone u_tone (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (ex_valid),
        .in_v      (ex_v),
        .cfg       (cfg_reg),
        .out_valid (tn_valid),
        .out_rgb   (tn_rgb)
    );

    assign out_free = !out_valid_reg || m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= tn_valid;
            end
        end
        else if (en && tn_valid)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
            out_reg <= skid_valid_reg ? skid_reg : tn_rgb;
        else if (en && tn_valid)
            skid_reg <= tn_rgb;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata = out_reg;

    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid word held while output register is empty");

    a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_valid_reg) |-> $past(out_valid_reg && !m_axis_tready))
        else $error("skid register filled without an output stall");

    a_skid_drain: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(skid_valid_reg) |-> $past(m_axis_tready) && out_valid_reg)
        else $error("skid register drained without a taken output word");

    a_stall_catch: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !m_axis_tready && !skid_valid_reg && tn_valid)
        |=> skid_valid_reg)
        else $error("finished word lost while output stalled");

endmodule

>>> verif/testbench.sv
// Self-checking testbench for gamma_brightness_contrast_ramp.
// Carries its own predictor; needs just the RTL.
`timescale 1ns / 100ps

module testbench;

    localparam int LEVEL_SPAN = 255;
    localparam logic [7:0] REG_BRIGHTNESS = 8'd0;
    localparam logic [7:0] REG_CONTRAST = 8'd1;
    localparam logic [7:0] REG_GAMMA = 8'd2;
    localparam logic [7:0] REG_TEMPERATURE = 8'd3;
    localparam logic [7:0] REG_UNKNOWN = 8'd9;
    localparam int LATENCY = 45;
    localparam longint CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic [15:0] blue;
        logic [15:0] green;
        logic [15:0] red;
    } rgb_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [47:0] m_axis_tdata;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [7:0]  cfg_index;
    logic [15:0] cfg_data;

    // Local copy of the registers.
    logic [15:0]       bright_reg;
    logic [15:0]       contrast_reg;
    logic [15:0]       gamma_reg;
    logic signed [7:0] temp_reg;

    rgb_t   pending_rgb[$];
    int     errors;
    longint cycles;
    int     send_idle_pct;
    int     recv_stall_pct;
    logic [63:0] half_roots [17];

    gamma_brightness_contrast_ramp i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever
            #4 clk = ~clk;
    end

    function automatic logic [63:0] floor_sqrt(input logic [63:0] n);
        logic [63:0] rem;
        logic [63:0] res;
        logic [63:0] bitv;
        rem = n;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > rem)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (rem >= res + bitv)
            begin
                rem = rem - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
                res = res >> 1;
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // x^(e/4096) in Q1.16 via log2 by squaring and a root-table exp2.
    function automatic logic [16:0] raise_q16(input logic [16:0] x, input logic [15:0] e);
        int unsigned msb;
        logic [63:0] mant;
        logic [63:0] neg;
        logic [63:0] y;
        logic [63:0] ip;
        logic [63:0] r;
        logic [63:0] v;
        logic [15:0] frac;
        msb = 15;
        frac = 0;
        while (msb > 0 && x[msb] == 1'b0)
            msb--;
        mant = 64'(x) << (30 - msb);
        for (int j = 0; j < 16; j++)
        begin
            mant = (mant * mant) >> 30;
            frac = frac << 1;
            if (mant >= (64'd1 << 31))
            begin
                frac[0] = 1'b1;
                mant = mant >> 1;
            end
        end
        neg = 64'(16 - msb) * 64'd65536 - 64'(frac);
        y = (neg * 64'(e) + 64'd2048) >> 12;
        ip = y >> 16;
        if (ip > 16)
            return 17'd0;
        r = 64'd1 << 32;
        for (int j = 1; j <= 16; j++)
            if (y[16 - j])
                r = (r * half_roots[j] + (64'd1 << 31)) >> 32;
        v = (r + (64'd1 << (15 + ip))) >> (16 + ip);
        if (v > 64'd65536)
            v = 64'd65536;
        return v[16:0];
    endfunction

    function automatic logic [15:0] scale_channel(input longint base, input longint num,
                                                  input longint den);
        longint n;
        longint d;
        longint o;
        n = base * 65535 * num;
        d = den * 65536;
        o = (2 * n + d) / (2 * d);
        return (o > 65535) ? 16'hFFFF : o[15:0];
    endfunction

    function automatic rgb_t predict_rgb(input logic [7:0] level);
        logic [16:0] x;
        logic [16:0] v;
        longint t;
        longint base;
        longint temp;
        rgb_t res;
        if (level >= LEVEL_SPAN)
            x = 17'h10000;
        else
            x = 17'((longint'(level) * 131072 + LEVEL_SPAN) / (2 * LEVEL_SPAN));
        if (gamma_reg == 16'd4096 || x == 17'h10000)
            v = x;
        else if (gamma_reg == 0)
            v = 17'h10000;
        else if (x == 0)
            v = 0;
        else
            v = raise_q16(x, gamma_reg);
        t = (longint'(v) - 32768) * longint'(contrast_reg);
        base = ((t + 8192 + (64'sd1 << 32)) >>> 14) - (64'sd1 << 18);
        base = base + 2 * longint'(bright_reg);
        if (base < 0)
            base = 0;
        if (base > 65536)
            base = 65536;
        temp = temp_reg;
        if (temp > 100)
            temp = 100;
        if (temp < -100)
            temp = -100;
        res.red = scale_channel(base, 1000 + temp, 1000);
        res.green = scale_channel(base, 5000 + temp, 5000);
        res.blue = scale_channel(base, 1000 - temp, 1000);
        return res;
    endfunction

    // The channel drops valid for one cycle after every word.
    task automatic write_reg(input logic [7:0] idx, input logic [15:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
        case (idx)
            REG_BRIGHTNESS:  bright_reg = value;
            REG_CONTRAST:    contrast_reg = value;
            REG_GAMMA:       gamma_reg = value;
            REG_TEMPERATURE: temp_reg = value[7:0];
            default: ;
        endcase
    endtask

    task automatic wait_drained();
        while (pending_rgb.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 5)
            @(posedge clk);
    endtask

    // Sends one level; a known result, where given, is pushed instead of the prediction.
    task automatic send_level(input logic [7:0] level, input bit known, input rgb_t want);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= level;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        pending_rgb.push_back(known ? want : predict_rgb(level));
    endtask

    task automatic finish_burst();
        s_axis_tvalid <= 1'b0;
        wait_drained();
    endtask

    task automatic random_config();
        int pick;
        logic [15:0] g;
        pick = $urandom_range(9);
        if (pick < 2)
            g = 16'd4096;
        else if (pick == 2)
            g = 16'($urandom_range(65535));
        else if (pick == 3)
            g = 16'($urandom_range(16));
        else
            g = 16'($urandom_range(12000, 1000));
        write_reg(REG_GAMMA, g);
        write_reg(REG_BRIGHTNESS, ($urandom_range(3) == 0) ? 16'($urandom_range(65535))
                                                            : 16'($urandom_range(8192, 24576)));
        write_reg(REG_CONTRAST, ($urandom_range(3) == 0) ? 16'($urandom_range(65535))
                                                          : 16'($urandom_range(8192, 32768)));
        write_reg(REG_TEMPERATURE, ($urandom_range(4) == 0) ? 16'($urandom_range(255))
                                                             : 16'($urandom_range(200) - 100));
    endtask

    // Output checker.
    always @(posedge clk)
    begin
        rgb_t got;
        rgb_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = m_axis_tdata;
            if (pending_rgb.size() == 0)
            begin
                $display("%0t: unexpected word, expected none, actual %h", $time, got);
                errors++;
            end
            else
            begin
                want = pending_rgb.pop_front();
                if (got.red !== want.red)
                begin
                    $display("%0t: red expected %0d actual %0d", $time, want.red, got.red);
                    errors++;
                end
                if (got.green !== want.green)
                begin
                    $display("%0t: green expected %0d actual %0d", $time, want.green,
                             got.green);
                    errors++;
                end
                if (got.blue !== want.blue)
                begin
                    $display("%0t: blue expected %0d actual %0d", $time, want.blue, got.blue);
                    errors++;
                end
            end
        end
    end

    // Sink-side backpressure.
    always @(posedge clk)
    begin
        if (recv_stall_pct != 0 && $urandom_range(99) < recv_stall_pct)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= 1'b1;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    typedef struct {
        logic [15:0] gamma;
        logic [15:0] bright;
        logic [15:0] contrast;
        logic [15:0] temp;
        logic [7:0]  level;
        bit          known;
        rgb_t        want;
    } vector_t;

    localparam rgb_t RGB_ZERO = '{16'd0, 16'd0, 16'd0};
    localparam rgb_t RGB_FULL = '{16'hFFFF, 16'hFFFF, 16'hFFFF};

    vector_t vectors [] = '{
        // Neutral settings after reset: black, full scale and a mid level.
        '{16'd4096, 16'd16384, 16'd16384, 16'd0, 8'd0, 1'b1, RGB_ZERO},
        '{16'd4096, 16'd16384, 16'd16384, 16'd0, 8'd255, 1'b1, RGB_FULL},
        '{16'd4096, 16'd16384, 16'd16384, 16'd0, 8'd128, 1'b0, RGB_ZERO},
        // Zero exponent lifts every level to full scale.
        '{16'd0, 16'd16384, 16'd16384, 16'd0, 8'd0, 1'b1, RGB_FULL},
        '{16'd0, 16'd16384, 16'd16384, 16'd0, 8'd77, 1'b1, RGB_FULL},
        // Zero level stays black and full scale stays full under a real power; levels next to each end are predicted.
        '{16'd2000, 16'd16384, 16'd16384, 16'd0, 8'd0, 1'b1, RGB_ZERO},
        '{16'd2000, 16'd16384, 16'd16384, 16'd0, 8'd255, 1'b1, RGB_FULL},
        '{16'd2000, 16'd16384, 16'd16384, 16'd0, 8'd1, 1'b0, RGB_ZERO},
        '{16'd2000, 16'd16384, 16'd16384, 16'd0, 8'd254, 1'b0, RGB_ZERO},
        // Deep exponent pushes small levels to zero; a tiny exponent is tried as well.
        '{16'd65535, 16'd16384, 16'd16384, 16'd0, 8'd1, 1'b1, RGB_ZERO},
        '{16'd65535, 16'd16384, 16'd16384, 16'd0, 8'd200, 1'b0, RGB_ZERO},
        '{16'd1, 16'd16384, 16'd16384, 16'd0, 8'd3, 1'b0, RGB_ZERO},
        // Brightness and contrast extremes.
        '{16'd4096, 16'd0, 16'd16384, 16'd0, 8'd255, 1'b0, RGB_ZERO},
        '{16'd4096, 16'd65535, 16'd16384, 16'd0, 8'd0, 1'b1, RGB_FULL},
        '{16'd4096, 16'd16384, 16'd0, 16'd0, 8'd255, 1'b0, RGB_ZERO},
        '{16'd4096, 16'd16384, 16'd65535, 16'd0, 8'd0, 1'b1, RGB_ZERO},
        '{16'd4096, 16'd16384, 16'd65535, 16'd0, 8'd255, 1'b1, RGB_FULL},
        // Temperature extremes, in range and saturated.
        '{16'd4096, 16'd16384, 16'd16384, 16'd100, 8'd128, 1'b0, RGB_ZERO},
        '{16'd4096, 16'd16384, 16'd16384, 16'hFF9C, 8'd128, 1'b0, RGB_ZERO},
        '{16'd4096, 16'd16384, 16'd16384, 16'h007F, 8'd200, 1'b0, RGB_ZERO},
        '{16'd4096, 16'd16384, 16'd16384, 16'hFF80, 8'd200, 1'b0, RGB_ZERO},
        '{16'd4096, 16'd16384, 16'd16384, 16'hFF80, 8'd170, 1'b0, RGB_ZERO}
    };

    initial
    begin
        int phase;
        errors = 0;
        cycles = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b1;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        bright_reg = 16'd16384;
        contrast_reg = 16'd16384;
        gamma_reg = 16'd4096;
        temp_reg = 8'sd0;
        half_roots[0] = 0;
        half_roots[1] = floor_sqrt(64'd1 << 63);
        for (int j = 2; j <= 16; j++)
            half_roots[j] = floor_sqrt(half_roots[j - 1] << 32);
        repeat (4)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // The first two rows run on reset values; registers are written from then on.
        foreach (vectors[i])
        begin
            if (i >= 2)
            begin
                finish_burst();
                write_reg(REG_GAMMA, vectors[i].gamma);
                write_reg(REG_BRIGHTNESS, vectors[i].bright);
                write_reg(REG_CONTRAST, vectors[i].contrast);
                write_reg(REG_TEMPERATURE, vectors[i].temp);
            end
            send_level(vectors[i].level, vectors[i].known, vectors[i].want);
        end
        finish_burst();
        // A write to an unknown index must change nothing.
        write_reg(REG_UNKNOWN, 16'hFFFF);
        send_level(8'd90, 1'b0, RGB_ZERO);
        finish_burst();

        for (int burst = 0; burst < 30; burst++)
        begin
            phase = burst % 5;
            send_idle_pct = (phase == 1) ? 84 : (phase == 3) ? 30 : 0;
            recv_stall_pct = (phase == 2) ? 84 : (phase == 3) ? 30 : 0;
            random_config();
            for (int k = 0; k < 30; k++)
                send_level(($urandom_range(4) == 0) ? (($urandom_range(1) == 0) ? 8'd0 : 8'd255)
                                                    : 8'($urandom_range(255)), 1'b0, RGB_ZERO);
            finish_burst();
        end

        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

>>> sim.f
sv/gbc_pkg.sv
sv/gbc_log2.sv
sv/gbc_exp2.sv
sv/gbc_tone.sv
sv/gamma_brightness_contrast_ramp.sv
verif/testbench.sv
